// ----- rtl/tcmm_pkg.sv -----
`default_nettype none

package tcmm_pkg;

  localparam int unsigned CoreRowsDef = 8;
  localparam int unsigned CoreColsDef = 8;

  // temperature table always has one entry per mask bit
  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW       = 6;
  localparam int unsigned TempW      = 16;
  localparam int unsigned CountW     = 7;
  localparam int unsigned TimeW      = 48;

  localparam logic [TimeW-1:0] MigIntervalRst = 48'd1000000;

  localparam logic [1:0] CmdWrite   = 2'd0;
  localparam logic [1:0] CmdMap     = 2'd1;
  localparam logic [1:0] CmdMigrate = 2'd2;

  localparam logic [2:0] StChosen   = 3'd0;
  localparam logic [2:0] StShort    = 3'd1;
  localparam logic [2:0] StEmpty    = 3'd2;
  localparam logic [2:0] StMigrate  = 3'd3;
  localparam logic [2:0] StNoMig    = 3'd4;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [IdxW-1:0]   core_index;
    logic [TempW-1:0]  temperature;
    logic [CountW-1:0] core_count;
    logic [63:0]       available_mask;
    logic [63:0]       active_mask;
    logic [63:0]       busy_mask;
    logic [TimeW-1:0]  time_now;
  } req_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [IdxW-1:0] target_core;
    logic [IdxW-1:0] source_core;
    logic            last;
  } res_t;

  // control from the sequencer to the compare unit
  typedef struct packed {
    logic clear;
    logic step;
    logic hot;
  } cmp_ctrl_t;

  typedef struct packed {
    logic              found;
    logic [IdxW-1:0]   best_idx;
    logic [CountW-1:0] hits;
  } cmp_res_t;

endpackage

`default_nettype wire

// ----- rtl/tcmm_temp_mem.sv -----
`default_nettype none

module tcmm_temp_mem (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       wr_en_i,
  input  wire logic [tcmm_pkg::IdxW-1:0]  wr_addr_i,
  input  wire logic [tcmm_pkg::TempW-1:0] wr_data_i,
  input  wire logic [tcmm_pkg::IdxW-1:0]  rd_addr_i,
  output logic      [tcmm_pkg::TempW-1:0] rd_data_o
);

  logic [tcmm_pkg::TempW-1:0] mem [tcmm_pkg::TableDepth];
  logic [tcmm_pkg::TableDepth-1:0] valid_q;
  logic [tcmm_pkg::TempW-1:0] rd_q;
  logic rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

// ----- rtl/tcmm_cmp_unit.sv -----
`default_nettype none

module tcmm_cmp_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire tcmm_pkg::cmp_ctrl_t        ctrl_i,
  input  wire logic                       hit_i,
  input  wire logic [tcmm_pkg::IdxW-1:0]  idx_i,
  input  wire logic [tcmm_pkg::TempW-1:0] temp_i,
  output tcmm_pkg::cmp_res_t              res_o
);

  logic                         found_q;
  logic [tcmm_pkg::IdxW-1:0]    best_idx_q;
  logic [tcmm_pkg::TempW-1:0]   best_temp_q;
  logic [tcmm_pkg::CountW-1:0]  hits_q;
  logic                         better;

  // strict compare keeps the lowest index on a tie
  assign better = !found_q ||
                  (ctrl_i.hot ? (temp_i > best_temp_q) : (temp_i < best_temp_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      best_idx_q  <= '0;
      best_temp_q <= '0;
      hits_q      <= '0;
    end else if (ctrl_i.clear) begin
      found_q <= 1'b0;
      hits_q  <= '0;
    end else if (ctrl_i.step && hit_i) begin
      hits_q <= hits_q + tcmm_pkg::CountW'(1);
      if (better) begin
        found_q     <= 1'b1;
        best_idx_q  <= idx_i;
        best_temp_q <= temp_i;
      end
    end
  end

  assign res_o.found    = found_q;
  assign res_o.best_idx = best_idx_q;
  assign res_o.hits     = hits_q;

endmodule

`default_nettype wire

// ----- rtl/thermal_core_mapper_migrator.sv -----
`default_nettype none

// Thermal core mapper and migrator. Temperature beats (cmd 0) write a per-core
// table that reset clears to zero; writes to cores at or above
// CORE_ROWS*CORE_COLS (capped at 64) are dropped. A map beat (cmd 1) returns
// core_count results, coldest available core first, lowest index on a tie,
// last set on the final one; a count of zero or more than the available cores
// returns a single status result instead. A migrate beat (cmd 2) returns one
// result: a move from the hottest active core to the coldest idle core, or
// no migration when the interval since the last decision has not elapsed or
// no such pair exists. Every pick is one pass of a single compare unit over
// the temperature memory read port, one core per cycle. in_stall_o is high
// from acceptance of a map or migrate beat until the final result is in the
// output register. migration_interval is to be written through the cfg port
// while idle; the user is bound to this, the block itself does not enforce it.
module thermal_core_mapper_migrator #(
  parameter int unsigned CORE_ROWS = tcmm_pkg::CoreRowsDef,
  parameter int unsigned CORE_COLS = tcmm_pkg::CoreColsDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire tcmm_pkg::req_t             in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output tcmm_pkg::res_t                  out_data_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [tcmm_pkg::TimeW-1:0] cfg_data_i
);

  localparam int unsigned RawCores = CORE_ROWS * CORE_COLS;
  localparam int unsigned NCores   = (RawCores > 64) ? 64 : RawCores;
  localparam logic [tcmm_pkg::IdxW-1:0]   LastCore = tcmm_pkg::IdxW'(NCores - 1);
  localparam logic [tcmm_pkg::CountW-1:0] NCoresC  = tcmm_pkg::CountW'(NCores);

  typedef enum logic [2:0] {
    SIdle, SMigCheck, SScan, SDrain, SDecide, SEmit
  } state_e;

  typedef enum logic [1:0] {
    PhMap, PhHot, PhCold
  } phase_e;

  state_e state_q;
  phase_e phase_q;

  logic [63:0]                  wmask_q;
  logic [63:0]                  busy_q;
  logic [tcmm_pkg::CountW-1:0]  remain_q;
  logic [tcmm_pkg::TimeW-1:0]   now_q;
  logic [tcmm_pkg::TimeW-1:0]   last_mig_q;
  logic [tcmm_pkg::TimeW-1:0]   interval_q;
  logic [tcmm_pkg::IdxW-1:0]    scan_q;
  logic [tcmm_pkg::IdxW-1:0]    cmp_idx_q;
  logic                         step_q;
  logic                         clr_q;
  logic [tcmm_pkg::IdxW-1:0]    hot_q;
  logic                         hot_found_q;
  tcmm_pkg::res_t               res_q;
  tcmm_pkg::res_t               out_q;
  logic                         out_valid_q;

  logic                         in_accept;
  logic                         can_emit;
  logic                         wr_en;
  logic [tcmm_pkg::TempW-1:0]   rd_data;
  logic [tcmm_pkg::TimeW-1:0]   elapsed;
  logic [63:0]                  hot_bit;
  tcmm_pkg::cmp_ctrl_t          cmp_ctrl;
  tcmm_pkg::cmp_res_t           cmp_res;

  assign in_stall_o  = (state_q != SIdle);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign can_emit    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign elapsed     = now_q - last_mig_q;
  assign hot_bit     = 64'd1 << cmp_res.best_idx;

  assign wr_en = in_accept && (in_data_i.cmd == tcmm_pkg::CmdWrite) &&
                 ({1'b0, in_data_i.core_index} < NCoresC);

  tcmm_temp_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (in_data_i.core_index),
    .wr_data_i (in_data_i.temperature),
    .rd_addr_i (scan_q),
    .rd_data_o (rd_data)
  );

  assign cmp_ctrl.clear = clr_q;
  assign cmp_ctrl.step  = step_q;
  assign cmp_ctrl.hot   = (phase_q == PhHot);

  tcmm_cmp_unit u_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cmp_ctrl),
    .hit_i  (wmask_q[cmp_idx_q]),
    .idx_i  (cmp_idx_q),
    .temp_i (rd_data),
    .res_o  (cmp_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      phase_q     <= PhMap;
      wmask_q     <= '0;
      busy_q      <= '0;
      remain_q    <= '0;
      now_q       <= '0;
      last_mig_q  <= '0;
      interval_q  <= tcmm_pkg::MigIntervalRst;
      scan_q      <= '0;
      cmp_idx_q   <= '0;
      step_q      <= 1'b0;
      clr_q       <= 1'b0;
      hot_q       <= '0;
      hot_found_q <= 1'b0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        interval_q <= cfg_data_i;
      end

      // one compare per cycle trails the read address by the memory latency
      step_q    <= (state_q == SScan);
      cmp_idx_q <= scan_q;
      clr_q     <= 1'b0;

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        SIdle: begin
          if (in_accept) begin
            busy_q   <= in_data_i.busy_mask;
            remain_q <= in_data_i.core_count;
            now_q    <= in_data_i.time_now;
            unique case (in_data_i.cmd)
              tcmm_pkg::CmdMap: begin
                wmask_q <= in_data_i.available_mask;
                phase_q <= PhMap;
                if (in_data_i.core_count == '0) begin
                  res_q   <= '{status: tcmm_pkg::StEmpty, target_core: '0,
                               source_core: '0, last: 1'b1};
                  state_q <= SEmit;
                end else begin
                  scan_q  <= '0;
                  clr_q   <= 1'b1;
                  state_q <= SScan;
                end
              end
              tcmm_pkg::CmdMigrate: begin
                wmask_q <= in_data_i.active_mask;
                state_q <= SMigCheck;
              end
              default: begin
              end
            endcase
          end
        end

        SMigCheck: begin
          if (elapsed >= interval_q) begin
            last_mig_q <= now_q;
            phase_q    <= PhHot;
            scan_q     <= '0;
            clr_q      <= 1'b1;
            state_q    <= SScan;
          end else begin
            res_q   <= '{status: tcmm_pkg::StNoMig, target_core: '0,
                         source_core: '0, last: 1'b1};
            state_q <= SEmit;
          end
        end

        SScan: begin
          scan_q <= scan_q + tcmm_pkg::IdxW'(1);
          if (scan_q == LastCore) begin
            state_q <= SDrain;
          end
        end

        SDrain: begin
          state_q <= SDecide;
        end

        SDecide: begin
          unique case (phase_q)
            PhMap: begin
              if (cmp_res.hits < remain_q) begin
                res_q <= '{status: tcmm_pkg::StShort, target_core: '0,
                           source_core: '0, last: 1'b1};
              end else begin
                res_q <= '{status: tcmm_pkg::StChosen, target_core: cmp_res.best_idx,
                           source_core: '0,
                           last: (remain_q == tcmm_pkg::CountW'(1))};
                wmask_q  <= wmask_q & ~hot_bit;
                remain_q <= remain_q - tcmm_pkg::CountW'(1);
              end
              state_q <= SEmit;
            end
            PhHot: begin
              hot_q       <= cmp_res.best_idx;
              hot_found_q <= cmp_res.found;
              wmask_q     <= ~busy_q & ~(cmp_res.found ? hot_bit : 64'd0);
              phase_q     <= PhCold;
              scan_q      <= '0;
              clr_q       <= 1'b1;
              state_q     <= SScan;
            end
            default: begin
              if (hot_found_q && cmp_res.found) begin
                res_q <= '{status: tcmm_pkg::StMigrate, target_core: cmp_res.best_idx,
                           source_core: hot_q, last: 1'b1};
              end else begin
                res_q <= '{status: tcmm_pkg::StNoMig, target_core: '0,
                           source_core: '0, last: 1'b1};
              end
              state_q <= SEmit;
            end
          endcase
        end

        SEmit: begin
          if (can_emit) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            if (res_q.last) begin
              state_q <= SIdle;
            end else begin
              // next pick of the same map request
              scan_q  <= '0;
              clr_q   <= 1'b1;
              state_q <= SScan;
            end
          end
        end

        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- verif/tb_thermal_core_mapper_migrator.sv -----
module tb_thermal_core_mapper_migrator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCores = (tcmm_pkg::CoreRowsDef * tcmm_pkg::CoreColsDef > 64) ? 64 :
                          tcmm_pkg::CoreRowsDef * tcmm_pkg::CoreColsDef;
  localparam logic [63:0] CoreSet = (NCores >= 64) ? '1 : ((64'd1 << NCores) - 64'd1);
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int PassCycles = NCores + 3;
  localparam int DrainCycles = 2 * PassCycles + 16;
  localparam int RandPerPhase = 36;
  localparam int PressureBeat = 150;
  localparam int PressureCycles = 400;

  typedef struct {
    tcmm_pkg::req_t req;
    bit             typed;
    tcmm_pkg::res_t want;
  } row_t;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  tcmm_pkg::req_t in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  tcmm_pkg::res_t out_data_o;
  logic           cfg_valid_i;
  logic           cfg_ready_o;
  logic [47:0]    cfg_data_i;

  // predictor state
  logic [15:0]    core_temp [64];
  logic [47:0]    mig_last;
  logic [47:0]    mig_ivl;
  tcmm_pkg::res_t due_results[$];

  int unsigned errors = 0;
  int unsigned beats = 0;
  bit          src_fast = 1'b0;
  bit          snk_fast = 1'b0;

  thermal_core_mapper_migrator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("** thermal_core_mapper_migrator: FAILED **");
    $finish;
  end

  task automatic report_miss(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors++;
  endtask

  function automatic void queue_due(input tcmm_pkg::res_t r);
    due_results.insert(due_results.size(), r);
  endfunction

  function automatic row_t mk_row(input tcmm_pkg::req_t q, input bit typed,
                                  input tcmm_pkg::res_t want);
    row_t w;
    w.req   = q;
    w.typed = typed;
    w.want  = want;
    return w;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_mask();
    case ($urandom_range(0, 7))
      0: return '1;
      1: return '0;
      2: return rand64() & rand64() & rand64();
      3: return rand64() | rand64();
      default: return rand64();
    endcase
  endfunction

  // every field random; the mk_ helpers then fix the ones that matter
  function automatic tcmm_pkg::req_t rand_req();
    tcmm_pkg::req_t r;
    r.cmd            = 2'($urandom);
    r.core_index     = tcmm_pkg::IdxW'($urandom);
    r.temperature    = tcmm_pkg::TempW'($urandom);
    r.core_count     = tcmm_pkg::CountW'($urandom);
    r.available_mask = rand64();
    r.active_mask    = rand64();
    r.busy_mask      = rand64();
    r.time_now       = tcmm_pkg::TimeW'(rand64());
    return r;
  endfunction

  function automatic tcmm_pkg::req_t mk_write(input int idx, input logic [15:0] t);
    tcmm_pkg::req_t r;
    r = rand_req();
    r.cmd         = tcmm_pkg::CmdWrite;
    r.core_index  = idx[tcmm_pkg::IdxW-1:0];
    r.temperature = t;
    return r;
  endfunction

  function automatic tcmm_pkg::req_t mk_map(input int cnt, input logic [63:0] avail);
    tcmm_pkg::req_t r;
    r = rand_req();
    r.cmd            = tcmm_pkg::CmdMap;
    r.core_count     = cnt[tcmm_pkg::CountW-1:0];
    r.available_mask = avail;
    return r;
  endfunction

  function automatic tcmm_pkg::req_t mk_mig(input logic [47:0] now, input logic [63:0] act,
                                            input logic [63:0] busy);
    tcmm_pkg::req_t r;
    r = rand_req();
    r.cmd         = tcmm_pkg::CmdMigrate;
    r.time_now    = now;
    r.active_mask = act;
    r.busy_mask   = busy;
    return r;
  endfunction

  function automatic tcmm_pkg::res_t mk_res(input logic [2:0] st, input int tgt,
                                            input int src, input bit lst);
    tcmm_pkg::res_t r;
    r.status      = st;
    r.target_core = tgt[tcmm_pkg::IdxW-1:0];
    r.source_core = src[tcmm_pkg::IdxW-1:0];
    r.last        = lst;
    return r;
  endfunction

  // index scan, lowest index wins a tie, -1 when the mask is empty
  function automatic int pick_core(input logic [63:0] mask, input bit hottest);
    int best;
    best = -1;
    for (int c = 0; c < NCores; c++) begin
      if (mask[c] && (best < 0 || (hottest ? core_temp[c] > core_temp[best]
                                           : core_temp[c] < core_temp[best]))) begin
        best = c;
      end
    end
    return best;
  endfunction

  function automatic void plan_results(input tcmm_pkg::req_t r);
    logic [63:0] avail;
    logic [63:0] idle;
    logic [47:0] elapsed;
    int hot;
    int cold;
    bit moved;
    case (r.cmd)
      tcmm_pkg::CmdWrite: begin
        if (r.core_index < NCores) core_temp[r.core_index] = r.temperature;
      end
      tcmm_pkg::CmdMap: begin
        avail = r.available_mask & CoreSet;
        if (r.core_count == 0) begin
          queue_due(mk_res(tcmm_pkg::StEmpty, 0, 0, 1'b1));
        end else if (r.core_count > $countones(avail)) begin
          queue_due(mk_res(tcmm_pkg::StShort, 0, 0, 1'b1));
        end else begin
          for (int k = 0; k < r.core_count; k++) begin
            cold = pick_core(avail, 1'b0);
            avail[cold] = 1'b0;
            queue_due(mk_res(tcmm_pkg::StChosen, cold, 0, k == r.core_count - 1));
          end
        end
      end
      tcmm_pkg::CmdMigrate: begin
        moved = 1'b0;
        elapsed = r.time_now - mig_last;
        if (elapsed >= mig_ivl) begin
          hot = pick_core(r.active_mask & CoreSet, 1'b1);
          idle = ~r.busy_mask & CoreSet;
          if (hot >= 0) idle[hot] = 1'b0;
          cold = pick_core(idle, 1'b0);
          mig_last = r.time_now;
          if (hot >= 0 && cold >= 0) begin
            queue_due(mk_res(tcmm_pkg::StMigrate, cold, hot, 1'b1));
            moved = 1'b1;
          end
        end
        if (!moved) queue_due(mk_res(tcmm_pkg::StNoMig, 0, 0, 1'b1));
      end
      default: ;
    endcase
  endfunction

  function automatic tcmm_pkg::req_t next_item();
    logic [63:0] avail;
    logic [47:0] now;
    int unsigned pick;
    int cnt;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      next_item = rand_req();
      next_item.cmd = CmdUnused;
      return next_item;
    end
    if (pick <= 7) begin
      // narrow temperatures now and then so ties show up
      return mk_write($urandom_range(0, 63), ($urandom_range(0, 1) != 0) ?
                      tcmm_pkg::TempW'($urandom_range(0, 7)) :
                      tcmm_pkg::TempW'($urandom));
    end
    if (pick <= 15) begin
      avail = rand_mask();
      case ($urandom_range(0, 19))
        0: cnt = 0;
        1: cnt = $urandom_range(0, 127);
        2: begin
          avail = '1;
          cnt = NCores;
        end
        3: cnt = $countones(avail & CoreSet) + 1;
        default: cnt = $urandom_range(1, 6);
      endcase
      return mk_map(cnt, avail);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: now = mig_last + mig_ivl + tcmm_pkg::TimeW'($urandom_range(0, 3));
      4: now = mig_last + mig_ivl - 48'd1;
      5: now = mig_last + tcmm_pkg::TimeW'($urandom_range(0, 4095));
      6: now = mig_last - 48'd1;
      default: now = tcmm_pkg::TimeW'(rand64());
    endcase
    return mk_mig(now, rand_mask(), rand_mask());
  endfunction

  task automatic send_beat(input tcmm_pkg::req_t r, input bit typed,
                           input tcmm_pkg::res_t want);
    int unsigned gap;
    if ($urandom_range(0, 15) == 0) src_fast = ~src_fast;
    gap = src_fast ? 0 : $urandom_range(0, 15);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    plan_results(r);
    // typed rows give one result, taken from the table instead
    if (typed) due_results[due_results.size() - 1] = want;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_interval(input logic [47:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    mig_ivl = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : source
    row_t rows[$];
    logic [47:0] ivl_plan [5];
    tcmm_pkg::req_t r;
    int unsigned taken;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    foreach (core_temp[i]) core_temp[i] = '0;
    mig_last = '0;
    mig_ivl  = tcmm_pkg::MigIntervalRst;

    rows.insert(rows.size(), mk_row(mk_map(0, '1), 1'b1,
                                    mk_res(tcmm_pkg::StEmpty, 0, 0, 1'b1)));
    rows.insert(rows.size(), mk_row(mk_map(127, '1), 1'b1,
                                    mk_res(tcmm_pkg::StShort, 0, 0, 1'b1)));
    rows.insert(rows.size(), mk_row(mk_map(1, '0), 1'b1,
                                    mk_res(tcmm_pkg::StShort, 0, 0, 1'b1)));
    rows.insert(rows.size(), mk_row(mk_map(64, 64'hFFFF_FFFF_FFFF_FFFE), 1'b1,
                                    mk_res(tcmm_pkg::StShort, 0, 0, 1'b1)));
    // interval from reset not yet elapsed
    rows.insert(rows.size(), mk_row(mk_mig(48'd0, '1, '0), 1'b1,
                                    mk_res(tcmm_pkg::StNoMig, 0, 0, 1'b1)));
    rows.insert(rows.size(), mk_row(mk_mig(48'd999999, '1, '0), 1'b1,
                                    mk_res(tcmm_pkg::StNoMig, 0, 0, 1'b1)));
    // table is all zero after reset
    rows.insert(rows.size(), mk_row(mk_map(1, '1), 1'b1,
                                    mk_res(tcmm_pkg::StChosen, 0, 0, 1'b1)));
    rows.insert(rows.size(), mk_row(mk_map(1, 64'h8000_0000_0000_0000), 1'b1,
                                    mk_res(tcmm_pkg::StChosen, 63, 0, 1'b1)));
    rows.insert(rows.size(), mk_row(mk_write(0, 16'hFFFF), 1'b0, '0));
    rows.insert(rows.size(), mk_row(mk_write(63, 16'hFFFF), 1'b0, '0));
    rows.insert(rows.size(), mk_row(mk_write(1, 16'h1234), 1'b0, '0));
    rows.insert(rows.size(), mk_row(mk_write(2, 16'h0001), 1'b0, '0));
    rows.insert(rows.size(), mk_row(mk_write(7, 16'h0005), 1'b0, '0));
    rows.insert(rows.size(), mk_row(mk_mig(48'd1000000, '1, '0), 1'b0, '0));
    // nothing active, nothing idle, only the hottest idle
    rows.insert(rows.size(), mk_row(mk_mig(48'd2000000, '0, '0), 1'b1,
                                    mk_res(tcmm_pkg::StNoMig, 0, 0, 1'b1)));
    rows.insert(rows.size(), mk_row(mk_mig(48'd3000000, '1, '1), 1'b1,
                                    mk_res(tcmm_pkg::StNoMig, 0, 0, 1'b1)));
    rows.insert(rows.size(), mk_row(mk_mig(48'd4000000, '1, 64'hFFFF_FFFF_FFFF_FFFE), 1'b1,
                                    mk_res(tcmm_pkg::StNoMig, 0, 0, 1'b1)));
    rows.insert(rows.size(), mk_row(mk_map(64, '1), 1'b0, '0));
    rows.insert(rows.size(), mk_row(mk_map(2, 64'h8000_0000_0000_0001), 1'b0, '0));
    rows.insert(rows.size(), mk_row(mk_map(5, 64'hF0F0_0000_1234_8087), 1'b0, '0));
    r = rand_req();
    r.cmd = CmdUnused;
    rows.insert(rows.size(), mk_row(r, 1'b0, '0));
    // time wraps around
    rows.insert(rows.size(), mk_row(mk_mig(48'hFFFF_FFFF_FFFF, '1, rand64()), 1'b0, '0));
    rows.insert(rows.size(), mk_row(mk_mig(48'd5, '1, '0), 1'b1,
                                    mk_res(tcmm_pkg::StNoMig, 0, 0, 1'b1)));
    rows.insert(rows.size(), mk_row(mk_mig(48'd999999, rand64(), rand64()), 1'b0, '0));

    ivl_plan = '{48'd0, '1, 48'd1, tcmm_pkg::TimeW'($urandom_range(2, 5000)),
                 tcmm_pkg::TimeW'(rand64())};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) send_beat(rows[i].req, rows[i].typed, rows[i].want);

    for (int p = 0; p < 5; p++) begin
      settle();
      write_interval(ivl_plan[p]);
      taken = 0;
      while (taken < RandPerPhase) begin
        r = next_item();
        send_beat(r, 1'b0, '0);
        if (r.cmd != CmdUnused) taken++;
      end
    end

    settle();
    if (errors == 0) begin
      $display("** thermal_core_mapper_migrator: PASSED **");
    end else begin
      $display("** thermal_core_mapper_migrator: FAILED **");
    end
    $finish;
  end

  initial begin : sink
    int unsigned gap;
    tcmm_pkg::res_t want;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          report_miss($sformatf("beat %0d with nothing due: %p", beats, out_data_o));
        end else begin
          want = due_results.pop_front();
          if (out_data_o.status != want.status)
            report_miss($sformatf("beat %0d status %0d, want %0d",
                                  beats, out_data_o.status, want.status));
          if (out_data_o.target_core != want.target_core)
            report_miss($sformatf("beat %0d target_core %0d, want %0d",
                                  beats, out_data_o.target_core, want.target_core));
          if (out_data_o.source_core != want.source_core)
            report_miss($sformatf("beat %0d source_core %0d, want %0d",
                                  beats, out_data_o.source_core, want.source_core));
          if (out_data_o.last != want.last)
            report_miss($sformatf("beat %0d last %0b, want %0b",
                                  beats, out_data_o.last, want.last));
        end
        beats++;
        if ($urandom_range(0, 15) == 0) snk_fast = ~snk_fast;
        gap = snk_fast ? 0 : $urandom_range(0, 15);
        // one long hold so the block backs up into its input
        if (beats == PressureBeat) gap = PressureCycles;
        if (gap != 0) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
          repeat (gap) @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- files.f -----
rtl/tcmm_pkg.sv
rtl/tcmm_temp_mem.sv
rtl/tcmm_cmp_unit.sv
rtl/thermal_core_mapper_migrator.sv
verif/tb_thermal_core_mapper_migrator.sv
